// File: rtl/core/iqh_pkg.sv
// shared constants, codes and result type of the indexed min-heap queue
// no dependencies
package iqh_pkg;

	localparam int HEAP_CAPACITY_DEF = 1024;
	localparam int CELL_COUNT_DEF    = 4096;
	localparam int PRIORITY_BITS_DEF = 24;

	localparam int FUNC_W   = 2;
	localparam int CELL_W   = 12;
	localparam int PRIO_W   = 24;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 3;

	localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DEC    = 2'd2;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_LOWER = 3'd5;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CELL_W-1:0]   cell_id;
		logic [PRIO_W-1:0]   prio;
		logic [COUNT_W-1:0]  count;
	} iqh_res_t;

endpackage

// File: rtl/core/iqh_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module iqh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/iqh_cmp.sv
// shared priority comparator, greater or greater-or-equal
// no dependencies
module iqh_cmp #(
	parameter int PB = 24
) (
	input  logic [PB-1:0] a,
	input  logic [PB-1:0] b,
	input  logic          or_equal,
	output logic          go
);
	assign go = or_equal ? (a >= b) : (a > b);
endmodule

// File: rtl/core/iqh_seq.sv
// sequencer of the heap: clearing pass, lookup, sift up and sift down
// uses iqh_pkg and iqh_cmp; drives the heap and slot map rams of the top level
module iqh_seq
	import iqh_pkg::*;
#(
	parameter int HEAP_CAPACITY = HEAP_CAPACITY_DEF,
	parameter int CELL_COUNT    = CELL_COUNT_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
	localparam int AW  = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1,
	localparam int CW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1,
	localparam int HW  = CW + PRIORITY_BITS,
	localparam int MW  = AW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  logic [CELL_W-1:0] cell_req,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic              res_free,
	output logic              idle,
	output logic              done,
	output iqh_res_t          res,
	output logic              heap_we,
	output logic [AW-1:0]     heap_waddr,
	output logic [HW-1:0]     heap_wdata,
	output logic [AW-1:0]     heap_raddr,
	input  logic [HW-1:0]     heap_rdata,
	output logic              map_we,
	output logic [CW-1:0]     map_waddr,
	output logic [MW-1:0]     map_wdata,
	output logic [CW-1:0]     map_raddr,
	input  logic [MW-1:0]     map_rdata
);
	localparam int PB  = PRIORITY_BITS;
	localparam int SW  = $clog2(HEAP_CAPACITY + 1);
	localparam int CXW = AW + 2;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_LOOKUP  = 4'd2;
	localparam logic [3:0] S_DEC_CHK = 4'd3;
	localparam logic [3:0] S_UP_RD   = 4'd4;
	localparam logic [3:0] S_UP_CMP  = 4'd5;
	localparam logic [3:0] S_POP_R0  = 4'd6;
	localparam logic [3:0] S_POP_RL  = 4'd7;
	localparam logic [3:0] S_DN_RD1  = 4'd8;
	localparam logic [3:0] S_DN_RD2  = 4'd9;
	localparam logic [3:0] S_DN_CMP  = 4'd10;
	localparam logic [3:0] S_FINAL   = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	logic [3:0]          state_q;
	logic [FUNC_W-1:0]   func_q;
	logic [CW-1:0]       cell_q;
	logic [PB-1:0]       prio_q;
	logic [AW-1:0]       node_q;
	logic [SW-1:0]       size_q;
	logic                strict_q;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]       ocell_q;
	logic [PB-1:0]       oprio_q;
	logic [CW-1:0]       bcell_q;
	logic [PB-1:0]       bprio_q;
	logic [AW-1:0]       bslot_q;
	logic                bmoved_q;
	logic [CW-1:0]       clr_q;

	logic [31:0]   cell32, prio32, ocell32, oprio32;
	logic [CW-1:0] cell_in;
	logic [PB-1:0] prio_in;
	logic          cell_ok;
	logic [CW-1:0] rcell;
	logic [PB-1:0] rprio;
	logic          m_present;
	logic [AW-1:0] m_slot;
	logic [AW-1:0] parent;
	logic [CXW-1:0] c1, c2, size_x;
	logic          c1_ok, c2_ok;
	logic [SW-1:0] size_dec;
	logic [PB-1:0] cmp_a, cmp_b;
	logic          cmp_oreq, go;

	assign cell32   = 32'(cell_req);
	assign prio32   = 32'(priority_req);
	assign cell_in  = cell32[CW-1:0];
	assign prio_in  = prio32[PB-1:0];
	assign cell_ok  = cell32 < 32'(CELL_COUNT);
	assign rcell    = heap_rdata[HW-1:PB];
	assign rprio    = heap_rdata[PB-1:0];
	assign m_present = map_rdata[AW];
	assign m_slot   = map_rdata[AW-1:0];
	assign parent   = AW'((node_q - AW'(1)) >> 1);
	assign c1       = {1'b0, node_q, 1'b1};
	assign c2       = c1 + CXW'(1);
	assign size_x   = CXW'(size_q);
	assign c1_ok    = c1 < size_x;
	assign c2_ok    = c2 < size_x;
	assign size_dec = size_q - SW'(1);

	iqh_cmp #(.PB(PB)) u_cmp (.a(cmp_a), .b(cmp_b), .or_equal(cmp_oreq), .go(go));

	// comparator operands by step
	always_comb begin
		cmp_a    = rprio;
		cmp_b    = prio_q;
		cmp_oreq = 1'b0;
		case (state_q)
			S_DEC_CHK: begin
				cmp_oreq = 1'b0;
			end
			S_UP_CMP: begin
				cmp_oreq = strict_q ? 1'b0 : 1'b1;
			end
			S_DN_RD2: begin
				cmp_a    = prio_q;
				cmp_b    = rprio;
				cmp_oreq = 1'b1;
			end
			S_DN_CMP: begin
				cmp_a    = bprio_q;
				cmp_b    = rprio;
				cmp_oreq = 1'b1;
			end
			default: begin
				cmp_oreq = 1'b0;
			end
		endcase
	end

	// ram ports
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = node_q;
		heap_wdata = {cell_q, prio_q};
		heap_raddr = '0;
		map_we     = 1'b0;
		map_waddr  = cell_q;
		map_wdata  = {1'b1, node_q};
		map_raddr  = cell_in;
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
			end
			S_LOOKUP: begin
				heap_raddr = m_slot;
			end
			S_POP_R0: begin
				heap_raddr = size_dec[AW-1:0];
				map_we     = 1'b1;
				map_waddr  = rcell;
				map_wdata  = '0;
			end
			S_UP_RD: begin
				heap_raddr = parent;
			end
			S_UP_CMP: begin
				heap_we    = go;
				heap_wdata = heap_rdata;
				map_we     = go;
				map_waddr  = rcell;
			end
			S_DN_RD1: begin
				heap_raddr = c1[AW-1:0];
			end
			S_DN_RD2: begin
				heap_raddr = c2[AW-1:0];
			end
			S_DN_CMP: begin
				if (c2_ok && go) begin
					heap_wdata = heap_rdata;
					map_waddr  = rcell;
				end else begin
					heap_wdata = {bcell_q, bprio_q};
					map_waddr  = bcell_q;
				end
				heap_we = bmoved_q || (c2_ok && go);
				map_we  = bmoved_q || (c2_ok && go);
			end
			S_FINAL: begin
				heap_we = 1'b1;
				map_we  = 1'b1;
			end
			default: begin
				heap_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			size_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CELL_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q   <= func;
						cell_q   <= cell_in;
						prio_q   <= prio_in;
						status_q <= ST_OK;
						ocell_q  <= '0;
						oprio_q  <= '0;
						if (func == FN_POP) begin
							if (size_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_POP_R0;
							end
						end else if (func == FN_PUSH || func == FN_DEC) begin
							if (!cell_ok) begin
								status_q <= ST_ABSENT;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_LOOKUP;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LOOKUP: begin
					if (func_q == FN_PUSH) begin
						strict_q <= 1'b0;
						if (m_present) begin
							status_q <= ST_PRESENT;
							state_q  <= S_DONE;
						end else if (32'(size_q) >= 32'(HEAP_CAPACITY)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							node_q  <= size_q[AW-1:0];
							size_q  <= size_q + SW'(1);
							state_q <= (size_q == '0) ? S_FINAL : S_UP_RD;
						end
					end else begin
						node_q <= m_slot;
						if (!m_present || SW'(m_slot) >= size_q) begin
							status_q <= ST_ABSENT;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_DEC_CHK;
						end
					end
				end
				S_DEC_CHK: begin
					strict_q <= 1'b1;
					if (!go) begin
						status_q <= ST_NOT_LOWER;
						state_q  <= S_DONE;
					end else begin
						state_q <= (node_q == '0) ? S_FINAL : S_UP_RD;
					end
				end
				S_UP_RD: begin
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (go) begin
						node_q  <= parent;
						state_q <= (parent == '0) ? S_FINAL : S_UP_RD;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_POP_R0: begin
					ocell_q <= rcell;
					oprio_q <= rprio;
					size_q  <= size_dec;
					state_q <= (size_dec == '0) ? S_DONE : S_POP_RL;
				end
				S_POP_RL: begin
					cell_q  <= rcell;
					prio_q  <= rprio;
					node_q  <= '0;
					state_q <= S_DN_RD1;
				end
				S_DN_RD1: begin
					state_q <= c1_ok ? S_DN_RD2 : S_FINAL;
				end
				S_DN_RD2: begin
					// first child against the moving entry
					if (go) begin
						bcell_q  <= rcell;
						bprio_q  <= rprio;
						bslot_q  <= c1[AW-1:0];
						bmoved_q <= 1'b1;
					end else begin
						bprio_q  <= prio_q;
						bmoved_q <= 1'b0;
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (c2_ok && go) begin
						node_q  <= c2[AW-1:0];
						state_q <= S_DN_RD1;
					end else if (bmoved_q) begin
						node_q  <= bslot_q;
						state_q <= S_DN_RD1;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ocell32     = 32'(ocell_q);
	assign oprio32     = 32'(oprio_q);
	assign idle        = state_q == S_IDLE;
	assign done        = (state_q == S_DONE) && res_free;
	assign res.status  = status_q;
	assign res.cell_id = ocell32[CELL_W-1:0];
	assign res.prio    = oprio32[PRIO_W-1:0];
	assign res.count   = COUNT_W'(size_q);
endmodule

// File: rtl/core/indexed_min_heap_queue_top.sv
// indexed binary min-heap open-set queue: push, pop minimum, decrease priority
// uses iqh_pkg, iqh_ram, iqh_cmp and iqh_seq
// a push or a decrease compares upward one parent at a time; a pop that leaves
// entries descends one level at a time, and one that empties the heap does not
// throughput: one request at a time, the next taken once the result is registered
// reset: asynchronous; the slot map is then swept clear, with in_ready low, before
// the first request is taken
module indexed_min_heap_queue_top
	import iqh_pkg::*;
#(
	parameter int HEAP_CAPACITY = HEAP_CAPACITY_DEF,
	parameter int CELL_COUNT    = CELL_COUNT_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [CELL_W-1:0]   cell_req,
	input  logic [PRIO_W-1:0]   priority_req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [CELL_W-1:0]   out_cell,
	output logic [PRIO_W-1:0]   out_priority,
	output logic [COUNT_W-1:0]  entry_count
);
	localparam int AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
	localparam int CW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int HW = CW + PRIORITY_BITS;
	localparam int MW = AW + 1;

	// heap ram ports
	logic          heap_we;
	logic [AW-1:0] heap_waddr, heap_raddr;
	logic [HW-1:0] heap_wdata, heap_rdata;
	// slot map ram ports
	logic          map_we;
	logic [CW-1:0] map_waddr, map_raddr;
	logic [MW-1:0] map_wdata, map_rdata;

	logic     start, idle, done, res_free;
	iqh_res_t res, res_q;
	logic     out_valid_q;

	// a request starts only when the sequencer is idle
	assign in_ready = idle;
	assign start    = in_valid && in_ready;
	// the output register frees when empty or drained this cycle
	assign res_free = !out_valid_q || out_ready;

	// heap entries: cell in the high bits, priority in the low bits
	iqh_ram #(.WIDTH(HW), .DEPTH(HEAP_CAPACITY)) u_heap_ram (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

	// slot map: present flag over heap slot
	iqh_ram #(.WIDTH(MW), .DEPTH(CELL_COUNT)) u_map_ram (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	iqh_seq #(
		.HEAP_CAPACITY(HEAP_CAPACITY),
		.CELL_COUNT(CELL_COUNT),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.cell_req(cell_req), .priority_req(priority_req), .res_free(res_free),
		.idle(idle), .done(done), .res(res),
		.heap_we(heap_we), .heap_waddr(heap_waddr), .heap_wdata(heap_wdata),
		.heap_raddr(heap_raddr), .heap_rdata(heap_rdata),
		.map_we(map_we), .map_waddr(map_waddr), .map_wdata(map_wdata),
		.map_raddr(map_raddr), .map_rdata(map_rdata)
	);

	// result register, holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign out_cell     = res_q.cell_id;
	assign out_priority = res_q.prio;
	assign entry_count  = res_q.count;

	// a taken request keeps the queue busy for at least the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("in_ready high right after a request was taken");

	// a finished request always lands in the result register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid)
		else $error("finished request not shown at the output");

	// only a successful pop reports a cell and priority
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_cell == '0 && out_priority == '0)
		else $error("payload set on a failed request");

	// empty status comes only from an empty heap
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0)
		else $error("empty status with entries present");
endmodule

// File: sim/iqh_checker.sv
// checker for the indexed min-heap queue: predicts each request's result and compares it
// depends on iqh_pkg
module iqh_checker
	import iqh_pkg::*;
#(
	parameter int HEAP_CAPACITY = HEAP_CAPACITY_DEF,
	parameter int CELL_COUNT    = CELL_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [CELL_W-1:0]   cell_req,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [STATUS_W-1:0] status,
	input  logic [CELL_W-1:0]   out_cell,
	input  logic [PRIO_W-1:0]   out_priority,
	input  logic [COUNT_W-1:0]  entry_count,
	output int                  fail_count,
	output int                  pending,
	output int                  live_size
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CELL_W-1:0]  hp_cell [HEAP_CAPACITY];
	logic [PRIO_W-1:0]  hp_prio [HEAP_CAPACITY];
	int                 slot_map [CELL_COUNT];
	bit                 present [CELL_COUNT];
	int                 size_q;
	iqh_res_t           want_q [$];

	assign pending   = want_q.size();
	assign live_size = size_q;

	initial begin
		fail_count = 0;
		size_q = 0;
		for (int i = 0; i < CELL_COUNT; i++) begin
			present[i] = 0;
			slot_map[i] = 0;
		end
	end

	function automatic void put_slot(int s, logic [CELL_W-1:0] c, logic [PRIO_W-1:0] p);
		hp_cell[s] = c;
		hp_prio[s] = p;
		slot_map[c] = s;
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [CELL_W-1:0] c;
		logic [PRIO_W-1:0] p;
		c = hp_cell[a];
		p = hp_prio[a];
		put_slot(a, hp_cell[b], hp_prio[b]);
		put_slot(b, c, p);
	endfunction

	function automatic void climb(int n, bit ties);
		int par;
		while (n != 0) begin
			par = (n - 1) / 2;
			if (ties ? (hp_prio[par] >= hp_prio[n]) : (hp_prio[par] > hp_prio[n])) begin
				swap_slots(par, n);
				n = par;
			end else
				break;
		end
	endfunction

	function automatic void descend();
		int n, best;
		n = 0;
		forever begin
			best = n;
			if (2*n+1 < size_q && hp_prio[n] >= hp_prio[2*n+1])
				best = 2*n+1;
			if (2*n+2 < size_q && hp_prio[best] >= hp_prio[2*n+2])
				best = 2*n+2;
			if (best == n)
				break;
			swap_slots(n, best);
			n = best;
		end
	endfunction

	function automatic iqh_res_t heap_result(logic [FUNC_W-1:0] f, logic [CELL_W-1:0] c,
			logic [PRIO_W-1:0] p);
		iqh_res_t r;
		int s;
		r = '0;
		r.status = ST_OK;
		if (f == FN_POP) begin
			if (size_q == 0)
				r.status = ST_EMPTY;
			else begin
				r.cell_id = hp_cell[0];
				r.prio = hp_prio[0];
				present[hp_cell[0]] = 0;
				size_q--;
				if (size_q > 0) begin
					put_slot(0, hp_cell[size_q], hp_prio[size_q]);
					descend();
				end
			end
		end else if (f == FN_PUSH || f == FN_DEC) begin
			if (int'(c) >= CELL_COUNT)
				r.status = ST_ABSENT;
			else if (f == FN_PUSH) begin
				if (present[c])
					r.status = ST_PRESENT;
				else if (size_q >= HEAP_CAPACITY)
					r.status = ST_FULL;
				else begin
					present[c] = 1;
					put_slot(size_q, c, p);
					size_q++;
					climb(size_q - 1, 1);
				end
			end else begin
				s = slot_map[c];
				if (!present[c] || s >= size_q)
					r.status = ST_ABSENT;
				else if (p >= hp_prio[s])
					r.status = ST_NOT_LOWER;
				else begin
					hp_prio[s] = p;
					climb(s, 0);
				end
			end
		end
		r.count = COUNT_W'(size_q);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int exp);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
		fail_count++;
	endtask

	always @(posedge clk) begin
		iqh_res_t w;
		if (arst_n) begin
			if (in_valid && in_ready)
				want_q = {want_q, heap_result(func, cell_req, priority_req)};
			if (out_valid && out_ready) begin
				if (want_q.size() == 0)
					report_mismatch("unexpected result", 1, 0);
				else begin
					w = want_q.pop_front();
					if (status !== w.status)
						report_mismatch("status", status, w.status);
					if (out_cell !== w.cell_id)
						report_mismatch("out_cell", out_cell, w.cell_id);
					if (out_priority !== w.prio)
						report_mismatch("out_priority", out_priority, w.prio);
					if (entry_count !== w.count)
						report_mismatch("entry_count", entry_count, w.count);
				end
			end
		end
	end
endmodule

// File: sim/tb_indexed_min_heap_queue_top.sv
// testbench top for the indexed min-heap queue: clock, reset, request stimulus, verdict
// depends on iqh_pkg, iqh_checker and the block's rtl
module tb_indexed_min_heap_queue_top;
	import iqh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_CAP   = HEAP_CAPACITY_DEF;
	localparam int CELLS      = CELL_COUNT_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = FN_PUSH;
	logic [CELL_W-1:0]   cell_req = '0;
	logic [PRIO_W-1:0]   priority_req = '0;
	logic                out_valid;
	logic                out_ready = 0;
	logic [STATUS_W-1:0] status;
	logic [CELL_W-1:0]   out_cell;
	logic [PRIO_W-1:0]   out_priority;
	logic [COUNT_W-1:0]  entry_count;
	int                  fail_count, pending, live_size;
	int                  idle_cycles = 0;
	bit                  hold_off = 0;   // long receiver stall requested by the stimulus

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	indexed_min_heap_queue_top DUT (.*);

	iqh_checker #(.HEAP_CAPACITY(HEAP_CAP), .CELL_COUNT(CELLS)) u_chk (.*);

	// short gaps mostly, occasionally a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offer one request and hold it until accepted
	task automatic send_req(logic [FUNC_W-1:0] f, logic [CELL_W-1:0] c, logic [PRIO_W-1:0] p);
		in_valid <= 1;
		func <= f;
		cell_req <= c;
		priority_req <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_gapped(logic [FUNC_W-1:0] f, logic [CELL_W-1:0] c,
			logic [PRIO_W-1:0] p, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		send_req(f, c, p);
	endtask

	// random request biased toward a small working set of cells so decreases hit
	task automatic send_random(bit gaps);
		int r;
		logic [FUNC_W-1:0] f;
		logic [CELL_W-1:0] c;
		logic [PRIO_W-1:0] p;
		r = $urandom_range(0, 99);
		if (r < 45) f = FN_PUSH;
		else if (r < 75) f = FN_POP;
		else if (r < 97) f = FN_DEC;
		else f = FN_UNUSED;
		c = ($urandom_range(0, 3) == 0) ? CELL_W'($urandom) : CELL_W'($urandom_range(0, 63));
		p = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 40));
		send_gapped(f, c, p, gaps);
	endtask

	// receiver: random stalls, or a long hold-off while the stimulus asks for one
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			g = ($urandom_range(0, 9) < 3) ? gap_len() : 0;
			if (g > 0) begin
				out_ready <= 0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	// watchdog: cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT + CELLS) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty pop, extremes, duplicate, absent, not lower
		send_req(FN_POP, '0, '0);
		send_req(FN_PUSH, 12'hFFF, 24'hFFFFFF);
		send_req(FN_PUSH, 12'd0, 24'd0);
		send_req(FN_PUSH, 12'd5, 24'd7);
		send_req(FN_PUSH, 12'd6, 24'd7);          // ties cell 5, climbs past parent
		send_req(FN_PUSH, 12'd5, 24'd1);          // already present
		send_req(FN_DEC, 12'd100, 24'd1);         // absent cell
		send_req(FN_DEC, 12'd5, 24'd7);           // equal, not lower
		send_req(FN_DEC, 12'd5, 24'd9);           // higher, not lower
		send_req(FN_DEC, 12'hFFF, 24'd3);         // lowers below its parent
		send_req(FN_DEC, 12'd6, 24'd0);           // ties root, strict compare
		send_req(FN_UNUSED, 12'hABC, 24'h555555); // unused code
		send_req(FN_POP, '0, '0);
		send_req(FN_POP, '0, '0);
		send_req(FN_DEC, 12'd0, 24'd0);           // popped, now absent
		send_req(FN_POP, '0, '0);
		send_req(FN_POP, '0, '0);
		send_req(FN_POP, '0, '0);                 // empty again
		send_req(FN_PUSH, 12'hAAA, 24'hAAAAAA);
		send_req(FN_PUSH, 12'h555, 24'h555555);
		send_req(FN_POP, '0, '0);
		send_req(FN_POP, '0, '0);

		// fill to capacity as a receiver hold-off begins, then push once more for full
		hold_off = 1;
		for (int i = 0; i < HEAP_CAP; i++)
			send_gapped(FN_PUSH, CELL_W'(i + 1000), PRIO_W'($urandom_range(0, 2000)), 0);
		send_req(FN_PUSH, 12'd7, 24'd1);
		send_req(FN_PUSH, 12'd1000, 24'd1);       // present beats full
		for (int i = 0; i < 40; i++)
			send_random(1);

		// sender pause until everything has drained
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// drain part of the heap, sorted order checked by the predictor
		n = live_size;
		for (int i = 0; i < n - 10 && i < 200; i++)
			send_gapped(FN_POP, CELL_W'($urandom), PRIO_W'($urandom), i % 50 > 40);

		for (int i = 0; i < 200; i++)
			send_random(i % 300 >= 100);

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
